// ----- hw/rtl/pqd_pkg.sv -----
// Shared types and constants for the posit16 quire dot-product block.
`timescale 1ns / 1ps
package pqd_pkg;

	localparam int QW = 128;
	localparam int PW = 30;
	localparam logic [15:0] NAR16 = 16'h8000;
	localparam logic [QW-1:0] NAR_Q = {1'b1, 127'b0};
	localparam logic CMD_ACC = 1'b0;
	localparam logic CMD_CLR = 1'b1;

	// product request handed from the decode front to the accumulate back
	typedef struct packed {
		logic clear;
		logic nar;
		logic zero;
		logic neg;
		logic [PW-1:0] prod;
		logic signed [7:0] shift;
	} item_t;

endpackage

// ----- hw/rtl/pqd_front.sv -----
// Front: accepts requests, decodes both posits, multiplies significands.
`timescale 1ns / 1ps
module pqd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           cmd,
	input  logic [15:0]    operand_a,
	input  logic [15:0]    operand_b,
	output logic           push,
	output pqd_pkg::item_t push_item,
	input  logic           push_ready
);

	typedef struct packed {
		logic signed [6:0] scale;
		logic [14:0] sig;
	} dec_t;

	function automatic dec_t decode(input logic [14:0] u);
		logic [15:0] t;
		logic [15:0] ts;
		logic r;
		logic run;
		logic [4:0] cnt;
		logic signed [5:0] k;
		dec_t d;
		t = {u[13:0], 2'b00};
		r = u[14];
		cnt = '0;
		run = 1'b1;
		for (int i = 0; i < 16; i++) begin
			if (run && (t[15-i] == r)) cnt = cnt + 5'd1;
			else run = 1'b0;
		end
		ts = t << cnt;
		k = r ? $signed({1'b0, cnt}) : -$signed({1'b0, cnt}) - 6'sd1;
		d.scale = $signed({k, ts[14]});
		d.sig = {1'b1, ts[13:0]};
		return d;
	endfunction

	logic v_s1, v_s2;
	logic clear_s1, nar_s1, zero_s1, neg_s1;
	logic [14:0] sig_a_s1, sig_b_s1;
	logic signed [7:0] shift_s1;
	pqd_pkg::item_t item_s2;
	logic adv1, adv2;
	logic [15:0] mag_a, mag_b;
	dec_t da, db;

	assign push = v_s2;
	assign push_item = item_s2;
	assign adv2 = !v_s2 || push_ready;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	assign mag_a = operand_a[15] ? 16'(-operand_a) : operand_a;
	assign mag_b = operand_b[15] ? 16'(-operand_b) : operand_b;
	assign da = decode(mag_a[14:0]);
	assign db = decode(mag_b[14:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			clear_s1 <= (cmd == pqd_pkg::CMD_CLR);
			nar_s1 <= (operand_a == pqd_pkg::NAR16) || (operand_b == pqd_pkg::NAR16);
			zero_s1 <= (operand_a == 16'h0) || (operand_b == 16'h0);
			neg_s1 <= operand_a[15] ^ operand_b[15];
			sig_a_s1 <= da.sig;
			sig_b_s1 <= db.sig;
			shift_s1 <= 8'sd28 + {da.scale[6], da.scale} + {db.scale[6], db.scale};
		end
		if (adv2) begin
			item_s2.clear <= clear_s1;
			item_s2.nar <= nar_s1;
			item_s2.zero <= zero_s1;
			item_s2.neg <= neg_s1;
			item_s2.prod <= sig_a_s1 * sig_b_s1;
			item_s2.shift <= shift_s1;
		end
	end

endmodule

// ----- hw/rtl/pqd_fifo.sv -----
// Two-entry queue between the decode front and the accumulate back.
`timescale 1ns / 1ps
module pqd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  pqd_pkg::item_t wr_item,
	output logic           rd_valid,
	input  logic           rd_ready,
	output pqd_pkg::item_t rd_item
);

	pqd_pkg::item_t mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic wr_en, rd_en;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_item = mem_q[rd_ptr_q];
	assign wr_en = wr_valid && wr_ready;
	assign rd_en = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= ~wr_ptr_q;
			if (rd_en) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

// ----- hw/rtl/pqd_back.sv -----
// Back: aligns the product, updates the quire, rounds the quire to posit16.
`timescale 1ns / 1ps
module pqd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rd_valid,
	output logic           rd_ready,
	input  pqd_pkg::item_t rd_item,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [63:0]    quire_high,
	output logic [63:0]    quire_low,
	output logic [15:0]    rounded
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_ALIGN = 7'b0000010,
		ST_ADD   = 7'b0000100,
		ST_ABS   = 7'b0001000,
		ST_NORM  = 7'b0010000,
		ST_ROUND = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t state_q;
	pqd_pkg::item_t item_q;
	logic [127:0] addend_q, accum_q, mag_q;
	logic qneg_q;
	logic [6:0] n_q;
	logic [15:0] z_q;
	logic out_valid_q;
	logic [63:0] out_high_q, out_low_q;
	logic [15:0] out_z_q;

	logic [127:0] wide_p, aligned, base, sum;
	logic [15:0] z_rnd;

	assign rd_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign quire_high = out_high_q;
	assign quire_low = out_low_q;
	assign rounded = out_z_q;

	assign wide_p = {{(128 - pqd_pkg::PW){1'b0}}, item_q.prod};
	assign aligned = item_q.shift[7] ? (wide_p >> 8'(-item_q.shift))
		: (wide_p << item_q.shift[6:0]);
	assign base = item_q.clear ? '0 : accum_q;
	assign sum = base + (addend_q ^ {128{item_q.neg}}) + {127'b0, item_q.neg};

	// round the normalized magnitude to nearest even, saturating
	always_comb begin
		logic signed [7:0] scale;
		logic signed [7:0] k;
		logic [7:0] rg;
		logic e, half, sticky;
		logic [63:0] frac;
		logic [6:0] sh;
		logic [15:0] regime, fr, z;
		scale = 8'sd71 - $signed({1'b0, n_q});
		k = scale >>> 1;
		e = scale[0];
		rg = k[7] ? 8'(-k) : 8'(k + 8'sd1);
		frac = {1'b0, mag_q[126:64]};
		sticky = (mag_q[63:0] != 64'b0);
		sh = 7'(rg) + 7'd50;
		half = 1'b0;
		fr = '0;
		regime = k[7] ? (16'h4000 >> rg) : (16'h7FFF - (16'h7FFF >> rg));
		if (rg > 8'd14) begin
			z = k[7] ? 16'h0001 : 16'h7FFF;
		end else begin
			if (rg != 8'd14) begin
				fr = 16'(frac >> sh);
				half = frac[6'(sh - 7'd1)];
				if ((frac & ((64'b1 << (sh - 7'd1)) - 64'b1)) != 64'b0) sticky = 1'b1;
				z = regime + (16'(e) << (8'd13 - rg)) + fr;
			end else begin
				if (frac != 64'b0) sticky = 1'b1;
				half = e;
				z = regime;
			end
			if (half) z = z + {15'b0, z[0] | sticky};
		end
		z_rnd = qneg_q ? 16'(-z) : z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			accum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !(state_q == ST_OUT)) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (rd_valid) state_q <= ST_ALIGN;
				ST_ALIGN: state_q <= ST_ADD;
				ST_ADD: begin
					if (base == pqd_pkg::NAR_Q || item_q.nar) accum_q <= pqd_pkg::NAR_Q;
					else if (item_q.zero) accum_q <= base;
					else if (sum == pqd_pkg::NAR_Q) accum_q <= '0;
					else accum_q <= sum;
					state_q <= ST_ABS;
				end
				ST_ABS: begin
					if (accum_q == '0 || accum_q == pqd_pkg::NAR_Q) state_q <= ST_OUT;
					else state_q <= ST_NORM;
				end
				ST_NORM: if (mag_q[127]) state_q <= ST_ROUND;
				ST_ROUND: state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (rd_valid) item_q <= rd_item;
			ST_ALIGN: addend_q <= aligned;
			ST_ABS: begin
				qneg_q <= accum_q[127];
				mag_q <= accum_q[127] ? (~accum_q + 128'd1) : accum_q;
				n_q <= '0;
				z_q <= (accum_q == '0) ? 16'h0000 : pqd_pkg::NAR16;
			end
			ST_NORM: begin
				if (mag_q[127:112] == 16'b0) begin
					mag_q <= mag_q << 16;
					n_q <= n_q + 7'd16;
				end else if (!mag_q[127]) begin
					mag_q <= mag_q << 1;
					n_q <= n_q + 7'd1;
				end
			end
			ST_ROUND: z_q <= z_rnd;
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_high_q <= accum_q[127:64];
					out_low_q <= accum_q[63:0];
					out_z_q <= z_q;
				end
			end
			default: ;
		endcase
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("back state not one-hot");
	a_nar_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD && item_q.nar) |=> (accum_q == pqd_pkg::NAR_Q))
		else $error("NaR operand did not poison quire");
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> mag_q[127])
		else $error("rounding an unnormalized magnitude");
	a_no_sum_nar: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD && !item_q.nar && base != pqd_pkg::NAR_Q)
		|=> (accum_q != pqd_pkg::NAR_Q))
		else $error("sum left on the NaR pattern");

endmodule

// ----- hw/rtl/posit16_quire_dot_product.sv -----
// Top level of the posit16 (es=1) quire dot-product accumulator.
`timescale 1ns / 1ps
// Each request carries two posit16 factors and a command (0 accumulate, 1 clear the
// quire first). The front decodes both factors and multiplies the significands in a
// two-stage pipeline, feeding a two-entry queue. The back aligns the exact product
// into the 128-bit quire (56 fraction bits), adds it, and rounds the new quire to
// posit16 (nearest even, saturating at maxpos/minpos; NaR is sticky until a clear).
// Throughput is set by the back sequencer, which takes one request at a time: align,
// add, absolute value, then a leading-zero normalizer that shifts by 16 or by 1 per
// cycle, then round, then output load; normalize and round are skipped when the quire
// is zero or NaR. The front keeps decoding while the back works, up to queue depth;
// results wait in an output register, and the back stalls while it is still unread.
module posit16_quire_dot_product (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [15:0] operand_a,
	input  logic [15:0] operand_b,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] quire_high,
	output logic [63:0] quire_low,
	output logic [15:0] rounded
);

	// front to queue
	logic f_push, f_ready;
	pqd_pkg::item_t f_item;
	// queue to back
	logic q_valid, q_ready;
	pqd_pkg::item_t q_item;

	pqd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .operand_a(operand_a), .operand_b(operand_b),
		.push(f_push), .push_item(f_item), .push_ready(f_ready)
	);

	pqd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_push), .wr_ready(f_ready), .wr_item(f_item),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
	);

	pqd_back u_back (
		.clk(clk), .arst_n(arst_n),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item),
		.out_valid(out_valid), .out_ready(out_ready),
		.quire_high(quire_high), .quire_low(quire_low), .rounded(rounded)
	);

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the posit16 quire dot-product accumulator.
`timescale 1ns / 1ps
module testbench;

	typedef struct {
		logic        cmd;
		logic [15:0] a;
		logic [15:0] b;
	} req_t;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
		logic [15:0] posit;
	} quire_res_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        cmd;
	logic [15:0] operand_a;
	logic [15:0] operand_b;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] quire_high;
	logic [63:0] quire_low;
	logic [15:0] rounded;

	posit16_quire_dot_product uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.quire_high(quire_high), .quire_low(quire_low), .rounded(rounded)
	);

	req_t        pending_reqs[$];
	quire_res_t  expected_quire[$];
	logic [127:0] model_quire;
	int          mismatches;
	int          cycle_count;
	bit          stim_done;
	int          hold_off;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// decode posit magnitude: scale and 15-bit significand (hidden bit at 14)
	function automatic void posit_decode(input logic [15:0] u, output int scale,
		output logic [14:0] sig);
		logic [15:0] t;
		int k;
		t = u << 2;
		if (u[14]) begin
			k = 0;
			for (int n = 0; n < 16 && t[15]; n++) begin
				k++;
				t = t << 1;
			end
		end else begin
			k = -1;
			for (int n = 0; n < 16 && !t[15]; n++) begin
				k--;
				t = t << 1;
			end
			t[15] = 1'b0;
		end
		scale = 2 * k + int'(t[15:14]);
		sig = 15'h4000 | t[14:0];
	endfunction

	function automatic logic [15:0] quire_round(input logic [127:0] q);
		logic neg, sticky, half;
		logic [127:0] m, norm;
		logic [63:0] top, frac;
		logic [15:0] regime, z;
		int n, scale, k, e, reg_len, sh;
		if (q == 128'd0) return 16'd0;
		if (q == pqd_pkg::NAR_Q) return pqd_pkg::NAR16;
		neg = q[127];
		m = neg ? -q : q;
		n = 0;
		while (n < 127 && !m[127 - n]) n++;
		norm = m << n;
		top = norm[127:64];
		sticky = norm[63:0] != 0;
		scale = 71 - n;
		k = ((scale + 128) >>> 1) - 64;
		e = scale - 2 * k;
		if (k < 0) begin
			reg_len = -k;
			regime = (reg_len <= 14) ? (16'h4000 >> reg_len) : 16'd0;
		end else begin
			reg_len = k + 1;
			regime = (reg_len <= 15) ? (16'h7FFF - (16'h7FFF >> reg_len)) : 16'd0;
		end
		half = 1'b0;
		if (reg_len > 14) begin
			z = (k >= 0) ? 16'h7FFF : 16'h0001;
		end else begin
			sh = reg_len + 50;
			frac = top & 64'h7FFF_FFFF_FFFF_FFFF;
			if (reg_len != 14) begin
				half = frac[sh-1];
				if ((frac << (65 - sh)) != 0) sticky = 1'b1;
				z = regime + (16'(e) << (13 - reg_len)) + 16'(frac >> sh);
			end else begin
				if (frac != 0) sticky = 1'b1;
				half = e != 0;
				z = regime;
			end
			if (half) z = z + (z[0] | sticky);
		end
		return neg ? -z : z;
	endfunction

	// advance the quire model by one request and queue its expected result
	function automatic void quire_accumulate(input req_t r);
		logic [15:0] a, b;
		logic [14:0] ga, gb;
		logic [127:0] prod;
		logic [29:0] p;
		int sa, sb, s;
		logic neg;
		quire_res_t res;
		a = r.a;
		b = r.b;
		if (r.cmd == pqd_pkg::CMD_CLR) model_quire = '0;
		if (model_quire == pqd_pkg::NAR_Q || a == pqd_pkg::NAR16 || b == pqd_pkg::NAR16) begin
			model_quire = pqd_pkg::NAR_Q;
		end else if (a != 0 && b != 0) begin
			neg = a[15] ^ b[15];
			if (a[15]) a = -a;
			if (b[15]) b = -b;
			posit_decode(a, sa, ga);
			posit_decode(b, sb, gb);
			p = ga * gb;
			s = 28 + sa + sb;
			// shift of 64 or more below bit 0 yields zero
			if (s < 0) prod = (-s < 64) ? (128'(p) >> (-s)) : '0;
			else if (s < 128) prod = 128'(p) << s;
			else prod = '0;
			if (neg) prod = -prod;
			model_quire = model_quire + prod;
			if (model_quire == pqd_pkg::NAR_Q) model_quire = '0;
		end
		res.hi = model_quire[127:64];
		res.lo = model_quire[63:0];
		res.posit = quire_round(model_quire);
		expected_quire.push_back(res);
	endfunction

	function automatic logic [15:0] rand_posit();
		case ($urandom_range(0, 9))
			0: return pqd_pkg::NAR16;
			1: return 16'h0000;
			2: return 16'h7FFF;
			3: return 16'h8001;
			4: return 16'(16'h0001 << $urandom_range(0, 14));
			5: return 16'($urandom_range(16'h3000, 16'h5000));
			6: return -16'($urandom_range(16'h3000, 16'h5000));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_req(input logic c, input logic [15:0] a, input logic [15:0] b);
		req_t r;
		r.cmd = c;
		r.a = a;
		r.b = b;
		pending_reqs.push_back(r);
	endtask

	// stimulus: directed corners, then random dot-product runs
	initial begin
		logic [15:0] x;
		add_req(pqd_pkg::CMD_CLR, 16'h4000, 16'h4000);
		add_req(pqd_pkg::CMD_ACC, 16'h0000, 16'h4000);
		add_req(pqd_pkg::CMD_ACC, 16'hC000, 16'h4000);
		add_req(pqd_pkg::CMD_ACC, 16'h7FFF, 16'h7FFF);
		add_req(pqd_pkg::CMD_ACC, 16'h7FFF, 16'h7FFF);
		add_req(pqd_pkg::CMD_CLR, 16'h0001, 16'h0001);
		add_req(pqd_pkg::CMD_ACC, 16'hFFFF, 16'h0001);
		add_req(pqd_pkg::CMD_CLR, 16'h8001, 16'h7FFF);
		add_req(pqd_pkg::CMD_ACC, 16'h8000, 16'h4000);
		add_req(pqd_pkg::CMD_ACC, 16'h4000, 16'h4000);
		add_req(pqd_pkg::CMD_CLR, 16'h4000, 16'h8000);
		add_req(pqd_pkg::CMD_CLR, 16'hFFFF, 16'hFFFF);
		add_req(pqd_pkg::CMD_CLR, 16'h7FFF, 16'h0001);
		add_req(pqd_pkg::CMD_CLR, 16'h5555, 16'hAAAB);
		add_req(pqd_pkg::CMD_ACC, 16'h3FFF, 16'h4001);
		// accumulate ten maxpos squares: large sums that stay short of the NaR pattern
		for (int i = 0; i < 10; i++) add_req(pqd_pkg::CMD_ACC, 16'h7FFF, 16'h7FFF);
		for (int i = 0; i < 1700; i++) begin
			x = rand_posit();
			add_req(($urandom_range(0, 15) == 0) ? pqd_pkg::CMD_CLR : pqd_pkg::CMD_ACC, x,
				($urandom_range(0, 3) == 0) ? x : rand_posit());
		end
		stim_done = 1'b1;
	end

	// accepted at the last rising edge?
	logic in_ready_q;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) in_ready_q <= 1'b0;
		else in_ready_q <= in_valid && in_ready;
	end

	// driver: bursts and gaps, updates only on the falling edge
	int burst_left;
	int gap_left;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd <= pqd_pkg::CMD_ACC;
			operand_a <= '0;
			operand_b <= '0;
			burst_left = 0;
			gap_left = 0;
		end else if (!in_valid || in_ready_q) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				req_t r;
				r = pending_reqs.pop_front();
				in_valid <= 1'b1;
				cmd <= r.cmd;
				operand_a <= r.a;
				operand_b <= r.b;
				quire_accumulate(r);
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
				end else begin
					burst_left--;
					if (burst_left == 0) gap_left = $urandom_range(0, 3) == 0 ? 0 :
						$urandom_range(1, 12);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: own stall pattern plus two long hold-offs
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_off = 0;
		end else if (hold_off > 0) begin
			hold_off--;
			out_ready <= 1'b0;
		end else if (cycle_count == 3000 || cycle_count == 20000) begin
			hold_off = 400;
			out_ready <= 1'b0;
		end else begin
			case ((cycle_count / 500) % 3)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(0, 3) != 0;
				default: out_ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_quire.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result hi=%h lo=%h rounded=%h",
						quire_high, quire_low, rounded);
			end else begin
				quire_res_t e;
				e = expected_quire.pop_front();
				if (quire_high !== e.hi || quire_low !== e.lo || rounded !== e.posit) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %h_%h/%h got %h_%h/%h",
							e.hi, e.lo, e.posit, quire_high, quire_low, rounded);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		mismatches = 0;
		cycle_count = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// wait for all requests to drain and all results to be checked, with a timeout
		while (!(stim_done && pending_reqs.size() == 0 && !in_valid
			&& expected_quire.size() == 0) && cycle_count < 400000) begin
			@(posedge clk);
			cycle_count++;
		end
		if (cycle_count >= 400000) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			repeat (50) @(posedge clk);
			if (mismatches == 0 && expected_quire.size() == 0) begin
				$display("TEST PASSED");
			end else begin
				$display("TEST FAILED");
			end
			$finish;
		end
	end

endmodule

// ----- files.f -----
hw/rtl/pqd_pkg.sv
hw/rtl/pqd_front.sv
hw/rtl/pqd_fifo.sv
hw/rtl/pqd_back.sv
hw/rtl/posit16_quire_dot_product.sv
dv/testbench.sv
